// ===== design/assert_macros.svh =====
// assertion helpers used by the top design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define IRTL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("irtl check failed");

// next-cycle implication, disabled while in reset
`define IRTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("irtl check failed");

`endif

// ===== design/irtl_pkg.sv =====
package irtl_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W     = 32;
    localparam int TAG_W    = 24;
    localparam int STATUS_W = 3;

    // item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 3'd0,
        STATUS_MISS     = 3'd1,
        STATUS_FULL     = 3'd2,
        STATUS_ORDER    = 3'd3,
        STATUS_BACKWARD = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [IP_W-1:0]  range_start;
        logic [IP_W-1:0]  range_end;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [TAG_W-1:0] tag;
    } result_t;

endpackage

// ===== design/irtl_table_ram.sv =====
module irtl_table_ram (
    input  logic                aclk,
    input  irtl_pkg::ram_req_t  req,
    output irtl_pkg::entry_t    rd_data
);

    irtl_pkg::entry_t mem [irtl_pkg::TABLE_DEPTH];
    irtl_pkg::entry_t rd_data_reg;

    // single write port, single registered read port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/irtl_search_ctrl.sv =====
module irtl_search_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [irtl_pkg::IP_W-1:0]           s_range_start,
    input  logic [irtl_pkg::IP_W-1:0]           s_range_end,
    input  logic [irtl_pkg::TAG_W-1:0]          s_range_tag,
    input  logic [irtl_pkg::IP_W-1:0]           s_address,
    output irtl_pkg::ram_req_t                  ram_req,
    input  irtl_pkg::entry_t                    ram_rd_data,
    input  logic                                buf_free,
    output irtl_pkg::result_t                   result
);

    irtl_pkg::state_t                    state_reg, state_next;
    logic [irtl_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [irtl_pkg::IP_W-1:0]           prev_end_reg, prev_end_next;
    logic [irtl_pkg::COUNT_W-1:0]        lo_reg, lo_next;
    logic [irtl_pkg::COUNT_W-1:0]        hi_reg, hi_next;
    logic [irtl_pkg::ADDR_W-1:0]         mid_reg, mid_next;
    logic [irtl_pkg::IP_W-1:0]           addr_reg, addr_next;
    irtl_pkg::status_t                   status_reg, status_next;
    logic [irtl_pkg::TAG_W-1:0]          tag_reg, tag_next;
    logic [irtl_pkg::COUNT_W-1:0]        span;
    logic [irtl_pkg::COUNT_W-1:0]        probe;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= irtl_pkg::ST_IDLE;
            count_reg    <= '0;
            prev_end_reg <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            prev_end_reg <= prev_end_next;
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        tag_reg    <= tag_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        prev_end_next = prev_end_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        addr_next     = addr_reg;
        status_next   = status_reg;
        tag_next      = tag_reg;
        span          = '0;
        probe         = '0;

        s_ready           = 1'b0;
        ram_req.we        = 1'b0;
        ram_req.waddr     = count_reg[irtl_pkg::ADDR_W-1:0];
        ram_req.wdata     = '{range_start: s_range_start, range_end: s_range_end,
                              tag: s_range_tag};
        ram_req.re        = 1'b0;
        ram_req.raddr     = mid_reg;
        result.valid      = 1'b0;
        result.status     = status_reg;
        result.tag        = tag_reg;

        case (state_reg)
            irtl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    tag_next  = '0;
                    addr_next = s_address;
                    if (s_kind == irtl_pkg::KIND_LOAD) begin
                        state_next = irtl_pkg::ST_DONE;
                        if (count_reg == irtl_pkg::COUNT_W'(irtl_pkg::TABLE_DEPTH)) begin
                            status_next = irtl_pkg::STATUS_FULL;
                        end else if (count_reg != '0 && s_range_start <= prev_end_reg) begin
                            status_next = irtl_pkg::STATUS_ORDER;
                        end else if (s_range_end < s_range_start) begin
                            status_next = irtl_pkg::STATUS_BACKWARD;
                        end else begin
                            status_next   = irtl_pkg::STATUS_OK;
                            ram_req.we    = 1'b1;
                            count_next    = count_reg + 1'b1;
                            prev_end_next = s_range_end;
                        end
                    end else if (count_reg == '0) begin
                        status_next = irtl_pkg::STATUS_MISS;
                        state_next  = irtl_pkg::ST_DONE;
                    end else begin
                        // first probe at the middle of the loaded entries
                        lo_next       = '0;
                        hi_next       = count_reg;
                        probe         = count_reg >> 1;
                        mid_next      = probe[irtl_pkg::ADDR_W-1:0];
                        ram_req.re    = 1'b1;
                        ram_req.raddr = mid_next;
                        state_next    = irtl_pkg::ST_SEARCH;
                    end
                end
            end
            irtl_pkg::ST_SEARCH: begin
                if (addr_reg < ram_rd_data.range_start) begin
                    hi_next = irtl_pkg::COUNT_W'(mid_reg);
                end else if (addr_reg > ram_rd_data.range_end) begin
                    lo_next = irtl_pkg::COUNT_W'(mid_reg) + 1'b1;
                end
                if (addr_reg >= ram_rd_data.range_start
                        && addr_reg <= ram_rd_data.range_end) begin
                    status_next = irtl_pkg::STATUS_OK;
                    tag_next    = ram_rd_data.tag;
                    state_next  = irtl_pkg::ST_DONE;
                end else if (lo_next < hi_next) begin
                    // next probe issued straight from the narrowed bounds
                    span          = hi_next - lo_next;
                    probe         = lo_next + (span >> 1);
                    mid_next      = probe[irtl_pkg::ADDR_W-1:0];
                    ram_req.re    = 1'b1;
                    ram_req.raddr = mid_next;
                end else begin
                    status_next = irtl_pkg::STATUS_MISS;
                    state_next  = irtl_pkg::ST_DONE;
                end
            end
            irtl_pkg::ST_DONE: begin
                result.valid = 1'b1;
                if (buf_free) begin
                    state_next = irtl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = irtl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ip_range_table_lookup_top.sv =====
// IPv4 range table lookup. A load word (kind 0) appends one range with its
// packed three-letter tag; it is rejected with table full, out of order (start
// not above the previous end while the table holds entries) or end before
// start, checked in that order, and a rejected range changes nothing. A lookup
// word (kind 1) binary-searches the loaded ranges and returns the tag of the
// range holding the address, or a miss with a zero tag. Every accepted word
// yields exactly one result word. The table lives in one synchronous ram of
// 4096 entries with one write port and one registered read port; no clearing
// pass is needed since only loaded entries are ever read, so the block is ready
// straight after reset.
// Timing: one word is worked on at a time. A load, or a lookup on an empty
// table, goes from idle to the done state and from there into the output
// register, and the block then returns to idle to take the next word. A
// lookup adds one search step per probe, each waiting on the registered ram
// read in the search loop; a full table needs at most 13 probes. A finished
// result sits in an output register so the next word can be taken while the
// result waits; a second finished result waits for that register to drain and
// holds the block meanwhile.
`include "assert_macros.svh"

module ip_range_table_lookup_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [irtl_pkg::IP_W-1:0]     s_range_start,
    input  logic [irtl_pkg::IP_W-1:0]     s_range_end,
    input  logic [irtl_pkg::TAG_W-1:0]    s_range_tag,
    input  logic [irtl_pkg::IP_W-1:0]     s_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [irtl_pkg::STATUS_W-1:0] m_status,
    output logic [irtl_pkg::TAG_W-1:0]    m_found_tag
);

    irtl_pkg::ram_req_t               ram_req;
    irtl_pkg::entry_t                 ram_rd_data;
    irtl_pkg::result_t                result;
    logic                             buf_free;

    // output word register
    logic                             out_valid_reg, out_valid_next;
    logic [irtl_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [irtl_pkg::TAG_W-1:0]       out_tag_reg, out_tag_next;

    irtl_table_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    irtl_search_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_range_start (s_range_start),
        .s_range_end   (s_range_end),
        .s_range_tag   (s_range_tag),
        .s_address     (s_address),
        .ram_req       (ram_req),
        .ram_rd_data   (ram_rd_data),
        .buf_free      (buf_free),
        .result        (result)
    );

    // the register can take a new word when empty or being drained now
    assign buf_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (result.valid && buf_free) begin
            out_valid_next  = 1'b1;
            out_status_next = result.status;
            out_tag_next    = result.tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_found_tag = out_tag_reg;

    // only one word in flight: taking a word always leaves the idle state
    `IRTL_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a miss or a rejected load never carries a tag
    `IRTL_ASSERT_IMPL(a_tag_only_on_ok, aclk, aresetn,
        m_valid && m_status != irtl_pkg::STATUS_OK, m_found_tag == '0)
    // the ram is never read and written in the same cycle
    `IRTL_ASSERT_IMPL(a_ram_single_access, aclk, aresetn, ram_req.we, !ram_req.re)
    // every status leaving the block is a defined code
    `IRTL_ASSERT_IMPL(a_status_defined, aclk, aresetn, m_valid,
        m_status <= irtl_pkg::STATUS_BACKWARD)

endmodule

// ===== bench/ip_range_table_lookup_top_tb.sv =====
module ip_range_table_lookup_top_tb;

    // one expected result word
    typedef struct {
        irtl_pkg::status_t          status;
        logic [irtl_pkg::TAG_W-1:0] tag;
    } verdict_t;

    // mirror of the range table, the expected result words and the run tallies
    class range_table_scoreboard;
        logic [irtl_pkg::IP_W-1:0]  first_addr [irtl_pkg::TABLE_DEPTH];
        logic [irtl_pkg::IP_W-1:0]  last_addr [irtl_pkg::TABLE_DEPTH];
        logic [irtl_pkg::TAG_W-1:0] range_tag [irtl_pkg::TABLE_DEPTH];
        int unsigned                loaded;
        logic [irtl_pkg::IP_W-1:0]  prev_last;
        verdict_t                   pending_results [$];
        int                         errors;
        int                         checked;
        int                         appended;
        int                         refused_full;
        int                         refused_order;
        int                         refused_backward;
        int                         hits;
        int                         misses;

        function new();
            loaded = 0;
            prev_last = '0;
            errors = 0;
            checked = 0;
            appended = 0;
            refused_full = 0;
            refused_order = 0;
            refused_backward = 0;
            hits = 0;
            misses = 0;
        endfunction

        // binary search over the loaded ranges
        function bit search_ranges(logic [irtl_pkg::IP_W-1:0] addr,
                                   output logic [irtl_pkg::TAG_W-1:0] tag);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = loaded;
            tag = '0;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (addr < first_addr[mid]) begin
                    hi = mid;
                end else if (addr > last_addr[mid]) begin
                    lo = mid + 1;
                end else begin
                    tag = range_tag[mid];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_word(logic kind, logic [irtl_pkg::IP_W-1:0] rs,
                                logic [irtl_pkg::IP_W-1:0] re,
                                logic [irtl_pkg::TAG_W-1:0] rt,
                                logic [irtl_pkg::IP_W-1:0] addr);
            verdict_t v;
            v.tag = '0;
            if (kind == irtl_pkg::KIND_LOAD) begin
                if (loaded >= irtl_pkg::TABLE_DEPTH) begin
                    v.status = irtl_pkg::STATUS_FULL;
                    refused_full++;
                end else if (loaded > 0 && rs <= prev_last) begin
                    v.status = irtl_pkg::STATUS_ORDER;
                    refused_order++;
                end else if (re < rs) begin
                    v.status = irtl_pkg::STATUS_BACKWARD;
                    refused_backward++;
                end else begin
                    first_addr[loaded] = rs;
                    last_addr[loaded] = re;
                    range_tag[loaded] = rt;
                    loaded++;
                    prev_last = re;
                    v.status = irtl_pkg::STATUS_OK;
                    appended++;
                end
            end else if (search_ranges(addr, v.tag)) begin
                v.status = irtl_pkg::STATUS_OK;
                hits++;
            end else begin
                v.status = irtl_pkg::STATUS_MISS;
                v.tag = '0;
                misses++;
            end
            pending_results.insert(pending_results.size(), v);
        endfunction

        function void check_word(logic [irtl_pkg::STATUS_W-1:0] status,
                                 logic [irtl_pkg::TAG_W-1:0] tag);
            verdict_t v;
            if (pending_results.size() == 0) begin
                $error("result word with nothing outstanding: status %0d found_tag %h",
                       status, tag);
                errors++;
                return;
            end
            v = pending_results.pop_front();
            checked++;
            if (status !== v.status) begin
                $error("status: expected %0d, got %0d", v.status, status);
                errors++;
            end
            if (tag !== v.tag) begin
                $error("found_tag: expected %h, got %h", v.tag, tag);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    localparam logic [irtl_pkg::TAG_W-1:0] TAG_USA = 24'h555341;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_kind;
    logic [irtl_pkg::IP_W-1:0]     s_range_start;
    logic [irtl_pkg::IP_W-1:0]     s_range_end;
    logic [irtl_pkg::TAG_W-1:0]    s_range_tag;
    logic [irtl_pkg::IP_W-1:0]     s_address;
    logic                          m_valid;
    logic                          m_ready;
    logic [irtl_pkg::STATUS_W-1:0] m_status;
    logic [irtl_pkg::TAG_W-1:0]    m_found_tag;

    range_table_scoreboard sb = new();

    bit idle_on = 1'b1;
    int hold_req = 0;

    ip_range_table_lookup_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_range_start (s_range_start),
        .s_range_end   (s_range_end),
        .s_range_tag   (s_range_tag),
        .s_address     (s_address),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_tag   (m_found_tag)
    );

    always #5 aclk = ~aclk;

    // offer one word, with an occasional gap first, and note it once taken
    task automatic send_word(logic kind, logic [irtl_pkg::IP_W-1:0] rs,
                             logic [irtl_pkg::IP_W-1:0] re,
                             logic [irtl_pkg::TAG_W-1:0] rt,
                             logic [irtl_pkg::IP_W-1:0] addr);
        if (idle_on && $urandom_range(99, 0) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_range_start <= rs;
        s_range_end <= re;
        s_range_tag <= rt;
        s_address <= addr;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_word(kind, rs, re, rt, addr);
    endtask

    // sender stays quiet until every outstanding result word is back
    task automatic wait_drained(int limit);
        int waited;
        waited = 0;
        if (sb.pending() != 0)
            s_valid <= 1'b0;
        while (sb.pending() != 0 && waited < limit) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.pending() != 0) begin
            $error("%0d result words never arrived", sb.pending());
            sb.errors++;
        end
    endtask

    function automatic logic [irtl_pkg::TAG_W-1:0] rand_tag();
        if ($urandom_range(1, 0))
            return {8'($urandom_range(90, 65)), 8'($urandom_range(90, 65)),
                    8'($urandom_range(90, 65))};
        return irtl_pkg::TAG_W'($urandom());
    endfunction

    // each new range lives in its own 1 MiB slot so a full table still fits
    function automatic logic [irtl_pkg::IP_W-1:0] slot_top();
        return (32'(sb.loaded) << 20) | 32'h000F_FFFF;
    endfunction

    function automatic logic [irtl_pkg::IP_W-1:0] lowest_start();
        return (sb.loaded == 0) ? 32'h0 : sb.prev_last + 32'h1;
    endfunction

    function automatic logic [irtl_pkg::IP_W-1:0] pick_address();
        int unsigned               j;
        logic [irtl_pkg::IP_W-1:0] a;
        if (sb.loaded == 0)
            return $urandom();
        j = $urandom_range(sb.loaded - 1, 0);
        case ($urandom_range(9, 0))
            0: a = sb.first_addr[j];
            1: a = sb.last_addr[j];
            2, 3, 4, 5: a = $urandom_range(sb.last_addr[j], sb.first_addr[j]);
            6: a = sb.last_addr[j] + 32'h1;
            7: a = sb.first_addr[j] - 32'h1;
            8: a = $urandom();
            default: a = $urandom_range(1, 0) ? 32'h0 : 32'hFFFF_FFFF;
        endcase
        return a;
    endfunction

    task automatic send_lookup();
        send_word(irtl_pkg::KIND_LOOKUP, $urandom(), $urandom(), rand_tag(), pick_address());
    endtask

    task automatic send_load_good();
        logic [irtl_pkg::IP_W-1:0] top;
        logic [irtl_pkg::IP_W-1:0] low;
        logic [irtl_pkg::IP_W-1:0] rs;
        logic [irtl_pkg::IP_W-1:0] re;
        top = slot_top();
        low = lowest_start();
        case ($urandom_range(3, 0))
            0: rs = low;
            1: rs = 32'(sb.loaded) << 20;
            default: rs = $urandom_range(top, low);
        endcase
        if (rs < low)
            rs = low;
        case ($urandom_range(3, 0))
            0: re = rs;
            1: re = top;
            2: re = $urandom_range(top, rs);
            default: re = rs + ((top - rs > 15) ? $urandom_range(15, 0) : 0);
        endcase
        send_word(irtl_pkg::KIND_LOAD, rs, re, rand_tag(), $urandom());
    endtask

    task automatic send_load_misordered();
        logic [irtl_pkg::IP_W-1:0] rs;
        case ($urandom_range(2, 0))
            0: rs = sb.prev_last;
            1: rs = $urandom_range(sb.prev_last, 0);
            default: rs = 32'h0;
        endcase
        send_word(irtl_pkg::KIND_LOAD, rs, $urandom(), rand_tag(), $urandom());
    endtask

    task automatic send_load_backward();
        logic [irtl_pkg::IP_W-1:0] low;
        logic [irtl_pkg::IP_W-1:0] rs;
        logic [irtl_pkg::IP_W-1:0] re;
        low = lowest_start();
        if (low == 0)
            low = 32'h1;
        rs = $urandom_range(slot_top(), low);
        re = $urandom_range(1, 0) ? rs - 32'h1 : $urandom_range(rs - 32'h1, 0);
        send_word(irtl_pkg::KIND_LOAD, rs, re, rand_tag(), $urandom());
    endtask

    // result side: check every word taken, stall now and then or on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
                sb.check_word(m_status, m_found_tag);
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req = 0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(99, 0) < 10) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int i;
        int r;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_kind <= irtl_pkg::KIND_LOAD;
        s_range_start <= '0;
        s_range_end <= '0;
        s_range_tag <= '0;
        s_address <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table: lookups miss, any start is fine, only end before start fails
        send_word(irtl_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 24'hFFFFFF, 32'h0);
        send_word(irtl_pkg::KIND_LOOKUP, 32'h0, 32'hFFFF_FFFF, 24'h0, 32'hFFFF_FFFF);
        send_word(irtl_pkg::KIND_LOAD, 32'h5, 32'h4, TAG_USA, 32'h0);
        send_word(irtl_pkg::KIND_LOAD, 32'hFFFF_FFFF, 32'h0, 24'hFFFFFF, 32'hFFFF_FFFF);
        send_word(irtl_pkg::KIND_LOAD, 32'h0, 32'h0, 24'h0, 32'hFFFF_FFFF);
        // start equal to the previous end, then a lookup hit on address zero
        send_word(irtl_pkg::KIND_LOAD, 32'h0, 32'h0000_FFFF, TAG_USA, 32'h0);
        send_word(irtl_pkg::KIND_LOOKUP, 32'h0, 32'h0, 24'h0, 32'h0);
        send_word(irtl_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 32'h1);
        // adjacent range, all-ones tag
        send_word(irtl_pkg::KIND_LOAD, 32'h1, 32'h001F_FFFF, 24'hFFFFFF, 32'h0);
        send_word(irtl_pkg::KIND_LOAD, 32'h001F_FFFF, 32'h0030_0000, TAG_USA, 32'h0);
        // out of order takes precedence over end before start
        send_word(irtl_pkg::KIND_LOAD, 32'h0000_1000, 32'h0000_0FFF, TAG_USA, 32'h0);
        send_word(irtl_pkg::KIND_LOAD, 32'h0020_0005, 32'h0020_0004, TAG_USA, 32'h0);
        // rejected words left the previous end alone, so this one fits
        send_word(irtl_pkg::KIND_LOAD, 32'h0020_0000, 32'h0020_0000, TAG_USA,
                  32'hFFFF_FFFF);
        send_word(irtl_pkg::KIND_LOOKUP, $urandom(), $urandom(), rand_tag(), 32'h1);
        send_word(irtl_pkg::KIND_LOOKUP, $urandom(), $urandom(), rand_tag(), 32'h0010_0000);
        send_word(irtl_pkg::KIND_LOOKUP, $urandom(), $urandom(), rand_tag(), 32'h001F_FFFF);
        send_word(irtl_pkg::KIND_LOOKUP, $urandom(), $urandom(), rand_tag(), 32'h0020_0000);
        send_word(irtl_pkg::KIND_LOOKUP, $urandom(), $urandom(), rand_tag(), 32'h0020_0001);
        send_word(irtl_pkg::KIND_LOOKUP, $urandom(), $urandom(), rand_tag(), 32'hFFFF_FFFF);

        // mixed traffic while the table grows
        for (i = 0; i < 750; i++) begin
            if (i == 100)
                idle_on = 1'b0;
            if (i == 250)
                idle_on = 1'b1;
            if (i == 400)
                hold_req = 300;
            if (i == 600)
                wait_drained(5000);
            r = $urandom_range(99, 0);
            if (r < 45)
                send_lookup();
            else if (r < 85)
                send_load_good();
            else if (r < 93 && sb.loaded > 0)
                send_load_misordered();
            else
                send_load_backward();
        end

        wait_drained(5000);
        repeat (30) @(posedge aclk);
        $display("covered %0d words: %0d ranges appended, %0d refused as full,",
                 sb.checked, sb.appended, sb.refused_full);
        $display("%0d out of order, %0d end before start, %0d hits, %0d misses, %0d of %0d",
                 sb.refused_order, sb.refused_backward, sb.hits, sb.misses,
                 sb.loaded, irtl_pkg::TABLE_DEPTH);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
